// File: rtl/ens_pkg.sv
// Shared types and constants for the emboss normal shading pipeline.
`default_nettype none
package ens_pkg;
    localparam int LVL_W   = 8;
    localparam int DIFF_W  = LVL_W + 1;
    localparam int LIGHT_W = 16;
    localparam int GAIN_W  = 9;
    localparam int PROD_W  = DIFF_W + LIGHT_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int FAC_W   = SQ_W - 1;
    localparam int N_W     = 27;
    localparam int NN_W    = 52;
    localparam int P_W     = 32;
    localparam int ROOT_W  = NN_W / 2;
    localparam int SREM_W  = ROOT_W + 2;
    localparam int F_W     = 37;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z    = 2'd3;

    localparam logic [GAIN_W-1:0]  GAIN_RST    = 9'd128;
    localparam logic [LIGHT_W-1:0] LIGHT_Z_RST = 16'd16384;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic             border;
        logic             neg;
    } side_t;
endpackage
`default_nettype wire

// File: rtl/ens_front.sv
// Gradient, normal numerator, squared numerator and tangent length product.
`default_nettype none
module ens_front (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  wire                                 in_valid,
    input  wire  [ens_pkg::LVL_W-1:0]           left_level,
    input  wire  [ens_pkg::LVL_W-1:0]           right_level,
    input  wire  [ens_pkg::LVL_W-1:0]           up_level,
    input  wire  [ens_pkg::LVL_W-1:0]           down_level,
    input  ens_pkg::side_t                      in_side,
    input  wire signed [ens_pkg::LIGHT_W-1:0]   light_x,
    input  wire signed [ens_pkg::LIGHT_W-1:0]   light_y,
    input  wire signed [ens_pkg::LIGHT_W-1:0]   light_z,
    output logic                                out_valid,
    output logic [ens_pkg::NN_W-1:0]            out_nn,
    output logic [ens_pkg::P_W-1:0]             out_p,
    output ens_pkg::side_t                      out_side
);
    logic signed [ens_pkg::DIFF_W-1:0] dx, dy;
    logic signed [ens_pkg::PROD_W-1:0] px_next, py_next;
    logic signed [ens_pkg::SQ_W-1:0]   dxsq, dysq;
    logic [ens_pkg::FAC_W-1:0]         sx_next, sy_next;

    logic                              v1_reg, v2_reg, v3_reg;
    logic signed [ens_pkg::PROD_W-1:0] px_reg, py_reg;
    logic [ens_pkg::FAC_W-1:0]         sx_reg, sy_reg;
    ens_pkg::side_t                    side1_reg, side2_reg, side3_reg;

    logic signed [ens_pkg::N_W-1:0]    n_next, n_reg;
    logic [2*ens_pkg::FAC_W-1:0]       pfull;
    logic [ens_pkg::P_W-1:0]           p2_reg, p3_reg;
    logic signed [2*ens_pkg::N_W-1:0]  nsq;
    logic [ens_pkg::NN_W-1:0]          nn_reg;

    assign dx = $signed({1'b0, left_level}) - $signed({1'b0, right_level});
    assign dy = $signed({1'b0, up_level}) - $signed({1'b0, down_level});
    assign px_next = dx * light_x;
    assign py_next = dy * light_y;
    assign dxsq = dx * dx;
    assign dysq = dy * dy;
    assign sx_next = dxsq[ens_pkg::FAC_W-1:0] + ens_pkg::FAC_W'(4);
    assign sy_next = dysq[ens_pkg::FAC_W-1:0] + ens_pkg::FAC_W'(4);

    assign n_next = (ens_pkg::N_W'(light_z) <<< 2)
                  - ((ens_pkg::N_W'(px_reg) + ens_pkg::N_W'(py_reg)) <<< 1);
    assign pfull = sx_reg * sy_reg;
    assign nsq = n_reg * n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            side1_reg <= in_side;
            n_reg     <= n_next;
            p2_reg    <= pfull[ens_pkg::P_W-1:0];
            side2_reg <= side1_reg;
            nn_reg    <= nsq[ens_pkg::NN_W-1:0];
            p3_reg    <= p2_reg;
            side3_reg <= '{red: side2_reg.red, green: side2_reg.green,
                           blue: side2_reg.blue, border: side2_reg.border,
                           neg: n_reg[ens_pkg::N_W-1]};
        end
    end

    assign out_valid = v3_reg;
    assign out_nn    = nn_reg;
    assign out_p     = p3_reg;
    assign out_side  = side3_reg;
endmodule
`default_nettype wire

// File: rtl/ens_div.sv
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module ens_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire  [ens_pkg::NN_W-1:0]     in_num,
    input  wire  [ens_pkg::P_W-1:0]      in_den,
    input  ens_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [ens_pkg::NN_W-1:0]     out_quo,
    output ens_pkg::side_t               out_side
);
    localparam int STAGES = ens_pkg::NN_W;

    logic                        valid_reg [STAGES];
    logic [ens_pkg::P_W-1:0]     rem_reg   [STAGES];
    logic [ens_pkg::NN_W-1:0]    num_reg   [STAGES];
    logic [ens_pkg::NN_W-1:0]    quo_reg   [STAGES];
    logic [ens_pkg::P_W-1:0]     den_reg   [STAGES];
    ens_pkg::side_t              side_reg  [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                     v_in;
        logic [ens_pkg::P_W-1:0]  rem_in;
        logic [ens_pkg::NN_W-1:0] num_in;
        logic [ens_pkg::NN_W-1:0] quo_in;
        logic [ens_pkg::P_W-1:0]  den_in;
        ens_pkg::side_t           side_in;
        logic [ens_pkg::P_W:0]    sh;
        logic                     qbit;
        logic [ens_pkg::P_W:0]    diff;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign num_in  = in_num;
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign num_in  = num_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign sh   = {rem_in, num_in[STAGES-1-i]};
        assign qbit = (sh >= {1'b0, den_in});
        assign diff = sh - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= qbit ? diff[ens_pkg::P_W-1:0] : sh[ens_pkg::P_W-1:0];
                num_reg[i]  <= num_in;
                quo_reg[i]  <= {quo_in[ens_pkg::NN_W-2:0], qbit};
                den_reg[i]  <= den_in;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
endmodule
`default_nettype wire

// File: rtl/ens_sqrt.sv
// Integer square root, one root bit per pipeline stage.
`default_nettype none
module ens_sqrt (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire  [ens_pkg::NN_W-1:0]     in_val,
    input  ens_pkg::side_t               in_side,
    output logic                         out_valid,
    output logic [ens_pkg::ROOT_W-1:0]   out_root,
    output ens_pkg::side_t               out_side
);
    localparam int STAGES = ens_pkg::ROOT_W;
    localparam int SH_W   = ens_pkg::SREM_W + 2;

    logic                          valid_reg [STAGES];
    logic [ens_pkg::SREM_W-1:0]    rem_reg   [STAGES];
    logic [ens_pkg::NN_W-1:0]      val_reg   [STAGES];
    logic [ens_pkg::ROOT_W-1:0]    root_reg  [STAGES];
    ens_pkg::side_t                side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                       v_in;
        logic [ens_pkg::SREM_W-1:0] rem_in;
        logic [ens_pkg::NN_W-1:0]   val_in;
        logic [ens_pkg::ROOT_W-1:0] root_in;
        ens_pkg::side_t             side_in;
        logic [SH_W-1:0]            sh;
        logic [SH_W-1:0]            trial;
        logic                       take;
        logic [SH_W-1:0]            diff;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign val_in  = in_val;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign sh    = {rem_in, val_in[ens_pkg::NN_W-1-2*k -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (sh >= trial);
        assign diff  = sh - trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? diff[ens_pkg::SREM_W-1:0] : sh[ens_pkg::SREM_W-1:0];
                val_reg[k]  <= val_in;
                root_reg[k] <= {root_in[ens_pkg::ROOT_W-2:0], take};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
endmodule
`default_nettype wire

// File: rtl/ens_shade.sv
// Blend factor, per channel scaling with saturation, output register.
`default_nettype none
module ens_shade (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire  [ens_pkg::ROOT_W-1:0]   in_root,
    input  ens_pkg::side_t               in_side,
    input  wire  [ens_pkg::GAIN_W-1:0]   blend_gain,
    output logic                         out_valid,
    output logic [ens_pkg::LVL_W-1:0]    red_out,
    output logic [ens_pkg::LVL_W-1:0]    green_out,
    output logic [ens_pkg::LVL_W-1:0]    blue_out
);
    localparam int GR_W = ens_pkg::GAIN_W + ens_pkg::ROOT_W;
    localparam int M_W  = ens_pkg::LVL_W + 1 + ens_pkg::F_W;
    localparam int FRAC = 22;

    logic signed [ens_pkg::GAIN_W:0]  omk;
    logic signed [ens_pkg::F_W-1:0]   base;
    logic [GR_W-1:0]                  gr;
    logic signed [ens_pkg::F_W-1:0]   f_next, f_reg;
    logic                             fv_reg, ov_reg;
    ens_pkg::side_t                   fside_reg;
    logic [ens_pkg::LVL_W-1:0]        r_reg, g_reg, b_reg;

    function automatic logic [ens_pkg::LVL_W-1:0] scale(
        input logic [ens_pkg::LVL_W-1:0] c,
        input logic signed [ens_pkg::F_W-1:0] f
    );
        logic signed [M_W-1:0] p;
        p = $signed({1'b0, c}) * f;
        if (p <= 0)
            return '0;
        else if (p[M_W-1:FRAC+ens_pkg::LVL_W] != '0)
            return '1;
        else
            return p[FRAC+ens_pkg::LVL_W-1:FRAC];
    endfunction

    assign omk  = $signed((ens_pkg::GAIN_W+1)'(256)) - $signed({1'b0, blend_gain});
    assign base = ens_pkg::F_W'(omk) <<< 14;
    assign gr   = blend_gain * in_root;
    assign f_next = in_side.neg ? base : base + $signed(ens_pkg::F_W'(gr));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (en) begin
            fv_reg <= in_valid;
            ov_reg <= fv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg     <= f_next;
            fside_reg <= in_side;
            r_reg <= fside_reg.border ? fside_reg.red   : scale(fside_reg.red, f_reg);
            g_reg <= fside_reg.border ? fside_reg.green : scale(fside_reg.green, f_reg);
            b_reg <= fside_reg.border ? fside_reg.blue  : scale(fside_reg.blue, f_reg);
        end
    end

    assign out_valid = ov_reg;
    assign red_out   = r_reg;
    assign green_out = g_reg;
    assign blue_out  = b_reg;
endmodule
`default_nettype wire

// File: rtl/emboss_normal_shading_top.sv
// Top level of the emboss normal shading pipeline.
// One pixel transfer is accepted per clock unless the output stalls; each
// result passes 3 front stages, 52 divider stages (one quotient bit each),
// 26 square root stages (one root bit each) and 2 shading stages. The whole
// pipeline advances together whenever the output register is empty or being
// taken. Configuration writes are always accepted and act at once.
`default_nettype none
module emboss_normal_shading_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [ens_pkg::LVL_W-1:0]         s_left_level,
    input  wire  [ens_pkg::LVL_W-1:0]         s_right_level,
    input  wire  [ens_pkg::LVL_W-1:0]         s_up_level,
    input  wire  [ens_pkg::LVL_W-1:0]         s_down_level,
    input  wire  [ens_pkg::LVL_W-1:0]         s_red_in,
    input  wire  [ens_pkg::LVL_W-1:0]         s_green_in,
    input  wire  [ens_pkg::LVL_W-1:0]         s_blue_in,
    input  wire                               s_on_border,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [ens_pkg::LVL_W-1:0]         m_red_out,
    output logic [ens_pkg::LVL_W-1:0]         m_green_out,
    output logic [ens_pkg::LVL_W-1:0]         m_blue_out,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [ens_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [ens_pkg::LIGHT_W-1:0]       cfg_data
);
    logic                          en;
    logic [ens_pkg::GAIN_W-1:0]    gain_reg;
    logic [ens_pkg::LIGHT_W-1:0]   lx_reg, ly_reg, lz_reg;
    ens_pkg::side_t                in_side, f_side, d_side, q_side;
    logic                          f_valid, d_valid, q_valid;
    logic [ens_pkg::NN_W-1:0]      f_nn, d_quo;
    logic [ens_pkg::P_W-1:0]       f_p;
    logic [ens_pkg::ROOT_W-1:0]    q_root;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= ens_pkg::GAIN_RST;
            lx_reg   <= '0;
            ly_reg   <= '0;
            lz_reg   <= ens_pkg::LIGHT_Z_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                ens_pkg::REG_BLEND_GAIN: gain_reg <= cfg_data[ens_pkg::GAIN_W-1:0];
                ens_pkg::REG_LIGHT_X:    lx_reg   <= cfg_data;
                ens_pkg::REG_LIGHT_Y:    ly_reg   <= cfg_data;
                ens_pkg::REG_LIGHT_Z:    lz_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_side = '{red: s_red_in, green: s_green_in, blue: s_blue_in,
                       border: s_on_border, neg: 1'b0};

    ens_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .left_level  (s_left_level),
        .right_level (s_right_level),
        .up_level    (s_up_level),
        .down_level  (s_down_level),
        .in_side     (in_side),
        .light_x     ($signed(lx_reg)),
        .light_y     ($signed(ly_reg)),
        .light_z     ($signed(lz_reg)),
        .out_valid   (f_valid),
        .out_nn      (f_nn),
        .out_p       (f_p),
        .out_side    (f_side)
    );

    ens_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_num    (f_nn),
        .in_den    (f_p),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    ens_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_val    (d_quo),
        .in_side   (d_side),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    ens_shade u_shade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (q_valid),
        .in_root    (q_root),
        .in_side    (q_side),
        .blend_gain (gain_reg),
        .out_valid  (m_valid),
        .red_out    (m_red_out),
        .green_out  (m_green_out),
        .blue_out   (m_blue_out)
    );
endmodule
`default_nettype wire
